// ----- rtl/core/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared types, character constants and the hex digit decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            last;
  } cmd_t;

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/url_percent_decoder_unit.sv -----
// The bytes of an item are written into the command queue and offered at the output from there.
// Throughput: one item per cycle while the queue is not full and each item yields at most one byte;
// an item that yields two or three bytes is sent one byte per result, and a four-command queue absorbs it.
// Reset: rst clears the escape state, the held digit and the queue.
// ----------------------------------------------------------------------------
// URL percent decoder unit
// Top level joining the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic push;
  logic pop;
  logic not_full;
  logic not_empty;
  cmd_t cmd;
  cmd_t head;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_ready  (not_full),
    .push     (push),
    .cmd      (cmd)
  );

  upd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (cmd),
    .not_full  (not_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ----- rtl/core/upd_front.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder front end
// Accepts input items, tracks the escape state and builds one output
// command of up to three bytes per item.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_ready,
  output logic       push,
  output cmd_t       cmd
);

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held;
  logic [7:0] held_next;

  function automatic cmd_t append(input cmd_t c, input logic [7:0] v);
    cmd_t r;
    r = c;
    case (c.count)
      2'd0: begin
        r.bytes[0] = v;
        r.count    = 2'd1;
      end
      2'd1: begin
        r.bytes[1] = v;
        r.count    = 2'd2;
      end
      2'd2: begin
        r.bytes[2] = v;
        r.count    = 2'd3;
      end
      default: r = c;
    endcase
    return r;
  endfunction

  always_comb begin
    logic [4:0] hv;
    logic [4:0] hh;
    logic       consumed;
    phase_t     ph;
    cmd_t       c;
    hv        = hex_value(in_byte);
    hh        = hex_value(held);
    consumed  = 1'b0;
    c         = '0;
    held_next = held;
    ph        = phase;
    unique case (phase)
      PH_DIGIT: begin
        if (!hv[4]) begin
          c        = append(c, {hh[3:0], hv[3:0]});
          consumed = 1'b1;
        end else begin
          c = append(c, CH_PCT);
          c = append(c, held);
        end
        ph        = PH_IDLE;
        held_next = 8'h00;
      end
      PH_PCT: begin
        if (!hv[4]) begin
          held_next = in_byte;
          ph        = PH_DIGIT;
          consumed  = 1'b1;
        end else begin
          c  = append(c, CH_PCT);
          ph = PH_IDLE;
        end
      end
      default: ph = PH_IDLE;
    endcase
    if (!consumed) begin
      if (in_byte == CH_PLUS) begin
        c = append(c, CH_SPACE);
      end else if (in_byte == CH_PCT) begin
        ph        = PH_PCT;
        held_next = 8'h00;
      end else begin
        c = append(c, in_byte);
      end
    end
    if (in_last) begin
      if (ph == PH_PCT || ph == PH_DIGIT) begin
        c = append(c, CH_PCT);
      end
      if (ph == PH_DIGIT) begin
        c = append(c, held_next);
      end
      ph        = PH_IDLE;
      held_next = 8'h00;
      c.last    = 1'b1;
    end
    phase_next = ph;
    cmd        = c;
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready && (cmd.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 8'h00;
    end else if (in_valid && in_ready) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

// ----- rtl/core/upd_queue.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder command queue
// Short first-in first-out store of commands between front and back end.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   fill;

  assign not_full  = (fill != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/upd_back.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder back end
// Sends the bytes of the head command one per result item.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [1:0] idx;
  logic       at_end;

  assign at_end    = (idx == head.count - 2'd1);
  assign out_valid = q_valid;
  assign out_last  = head.last && at_end;
  assign pop       = out_valid && out_ready && at_end;

  always_comb begin
    case (idx)
      2'd0:    out_byte = head.bytes[0];
      2'd1:    out_byte = head.bytes[1];
      default: out_byte = head.bytes[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ----- test/url_percent_decoder_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder unit testbench
// Sends directed and random encoded messages through the decoder under
// changing sender gaps and receiver stalls. A behavioral decoder predicts
// every output byte, and each result is checked in order against it.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit_test;
  import upd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;

  decoded_t   decoded_q[$];
  phase_t     dec_phase;
  logic [7:0] dec_held;

  int err_count;
  int items_sent;
  int snd_idle_pct;
  int rcv_stall_pct;
  int hold_left;
  bit hold_go;

  url_percent_decoder_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  always #4 clk = ~clk;

  function automatic bit is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    if (c <= 8'h39) begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  function automatic void add_decoded(input logic [7:0] b);
    decoded_t d;
    d.data = b;
    d.last = 1'b0;
    decoded_q.push_back(d);
  endfunction

  function automatic void decode_item(input logic [7:0] b, input logic last);
    int start;
    bit consumed;
    start = decoded_q.size();
    consumed = 0;
    case (dec_phase)
      PH_DIGIT: begin
        if (is_hex(b)) begin
          add_decoded({nibble(dec_held), nibble(b)});
          consumed = 1;
        end else begin
          add_decoded(CH_PCT);
          add_decoded(dec_held);
        end
        dec_phase = PH_IDLE;
        dec_held = 8'h00;
      end
      PH_PCT: begin
        if (is_hex(b)) begin
          dec_held = b;
          dec_phase = PH_DIGIT;
          consumed = 1;
        end else begin
          add_decoded(CH_PCT);
          dec_phase = PH_IDLE;
        end
      end
      default: begin
        dec_phase = PH_IDLE;
      end
    endcase
    if (!consumed) begin
      if (b == CH_PLUS) begin
        add_decoded(CH_SPACE);
      end else if (b == CH_PCT) begin
        dec_phase = PH_PCT;
        dec_held = 8'h00;
      end else begin
        add_decoded(b);
      end
    end
    if (last) begin
      if (dec_phase != PH_IDLE) begin
        add_decoded(CH_PCT);
      end
      if (dec_phase == PH_DIGIT) begin
        add_decoded(dec_held);
      end
      dec_phase = PH_IDLE;
      dec_held = 8'h00;
      if (decoded_q.size() > start) begin
        decoded_q[decoded_q.size() - 1].last = 1'b1;
      end
    end
  endfunction

  function automatic logic [7:0] rand_hex_char();
    case ($urandom_range(2))
      0: return 8'h30 + 8'($urandom_range(9));
      1: return 8'h41 + 8'($urandom_range(5));
      default: return 8'h61 + 8'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (is_hex(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (c == CH_PCT);
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    decode_item(b, last);
    items_sent++;
  endtask

  task automatic send_message();
    logic [7:0] msg[$];
    int ntok;
    if ($urandom_range(99) < 12) begin
      ntok = $urandom_range(1, 10);
      repeat (ntok) msg.push_back(8'($urandom));
    end else begin
      ntok = $urandom_range(1, 8);
      repeat (ntok) begin
        case ($urandom_range(9))
          0, 1, 2, 3: msg.push_back(rand_plain());
          4: msg.push_back(CH_PLUS);
          5, 6, 7: begin
            msg.push_back(CH_PCT);
            msg.push_back(rand_hex_char());
            msg.push_back(rand_hex_char());
          end
          8: begin
            msg.push_back(CH_PCT);
            msg.push_back(rand_non_hex());
          end
          default: begin
            msg.push_back(CH_PCT);
            msg.push_back(rand_hex_char());
            msg.push_back(rand_non_hex());
          end
        endcase
      end
      if ($urandom_range(99) < 20) begin
        msg.push_back(CH_PCT);
        if ($urandom_range(1) == 1) begin
          msg.push_back(rand_hex_char());
        end
      end
    end
    foreach (msg[i]) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
  endtask

  task automatic drain_decoder();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_PLUS, 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte("4", 1'b0);
    send_byte("1", 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte("f", 1'b0);
    send_byte("F", 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte("G", 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte("4", 1'b0);
    send_byte("Z", 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte("2", 1'b0);
    send_byte(CH_PLUS, 1'b0);
    send_byte(CH_PCT, 1'b1);
    send_byte(CH_PCT, 1'b0);
    send_byte("a", 1'b1);
    send_byte(CH_PCT, 1'b0);
    send_byte("7", 1'b0);
    send_byte(CH_PCT, 1'b1);
    send_byte("x", 1'b1);
  endtask

  task automatic test_random_messages(input int snd_pct, input int rcv_pct, input int count);
    int target;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    target = items_sent + count;
    while (items_sent < target) begin
      send_message();
    end
  endtask

  task automatic test_output_holdoff();
    int target;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_go = 1'b1;
    target = items_sent + 40;
    while (items_sent < target) begin
      send_message();
    end
    drain_decoder();
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result out_byte %02h out_last %0b",
                 $time, out_byte, out_last);
        err_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
          err_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 90;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_last = 1'b0;
    out_ready = 1'b0;
    err_count = 0;
    items_sent = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_left = 0;
    hold_go = 1'b0;
    dec_phase = PH_IDLE;
    dec_held = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_messages(0, 0, 80);
    test_random_messages(46, 0, 80);
    test_random_messages(0, 46, 80);
    test_random_messages(24, 24, 80);
    test_output_holdoff();
    drain_decoder();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/upd_pkg.sv
rtl/core/upd_front.sv
rtl/core/upd_queue.sv
rtl/core/upd_back.sv
rtl/core/url_percent_decoder_unit.sv
test/url_percent_decoder_unit_test.sv
